// ===== hdl/dtq_pkg.sv =====
package dtq_pkg;

  localparam int NumLevelsDef  = 4;
  localparam int QueueDepthDef = 8;
  localparam int NumTimersDef  = 16;

  localparam int TimeW = 48;
  localparam int OpW   = 3;
  localparam int IdW   = 8;
  localparam int TidW  = 4;
  localparam int PrioW = 2;

  localparam logic [OpW-1:0] OP_POST     = 3'd0;
  localparam logic [OpW-1:0] OP_EXP_ABS  = 3'd1;
  localparam logic [OpW-1:0] OP_EXP_REL  = 3'd2;
  localparam logic [OpW-1:0] OP_ARM      = 3'd3;
  localparam logic [OpW-1:0] OP_CANCEL   = 3'd4;
  localparam logic [OpW-1:0] OP_TICK     = 3'd5;
  localparam logic [OpW-1:0] OP_DISPATCH = 3'd6;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_TASK  = 2'd1;
  localparam logic [1:0] KIND_TIMER = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Command broadcast along the timer cell chain.
  typedef struct packed {
    logic             set_exp;  // write expiry and disarm
    logic             arm;
    logic             disarm;   // cancel or fire of the addressed cell
    logic [5:0]       sel;      // addressed cell
    logic [TimeW-1:0] expiry;
    logic [PrioW-1:0] level;
  } dtq_cmd_t;

  // Best candidate travelling down the chain.
  typedef struct packed {
    logic             found;
    logic [5:0]       idx;
    logic [TimeW-1:0] expiry;
    logic [6:0]       order;
    logic [PrioW-1:0] level;
  } dtq_cand_t;

endpackage

// ===== hdl/deadline_timer_priority_ready_queue_top.sv =====
// Post, expiry, arm and cancel pass through a scan state and an output state, then answer.
// Tick walks the timer cell chain once per fired timer plus a final pass that finds none; each
// firing is one registered pass through the timer cell chain, eight cells per cycle.
// Dispatch gives its beats from the highest level down, passing over empty levels;
// an empty dispatch answers with a single status beat.
// One item at a time; s_axis_tready is low while an item or a result beat is in work.
// Synchronous active-high reset empties all queues and disarms all timers.
module deadline_timer_priority_ready_queue_top #(
  parameter int NUM_LEVELS  = dtq_pkg::NumLevelsDef,
  parameter int QUEUE_DEPTH = dtq_pkg::QueueDepthDef,
  parameter int NUM_TIMERS  = dtq_pkg::NumTimersDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[2:0], task_id[10:3], timer_id[14:11], prio[16:15], time_req[64:17], zero
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // kind[1:0], item_id[9:2], was_cancelled[10], item_prio[12:11], status[14:13],
  // fired_count[19:15], zero
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  import dtq_pkg::*;

  localparam int LW  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int MW  = $clog2(NUM_LEVELS * QUEUE_DEPTH);
  localparam int SEG = 8;
  localparam int NSEG = (NUM_TIMERS + SEG - 1) / SEG;
  localparam int SW  = $clog2(NSEG + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_FIRE = 3'd2;
  localparam logic [2:0] S_DISP = 3'd3;
  localparam logic [2:0] S_READ = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state;
  logic [OpW-1:0]   op;
  logic [IdW-1:0]   task_id;
  logic [TidW-1:0]  timer_id;
  logic [PrioW-1:0] lvl;
  logic [TimeW-1:0] treq, current_time;
  logic [6:0] arm_sequence;
  logic [1:0] st;
  logic [4:0] fired;

  logic [QW-1:0] heads [NUM_LEVELS];
  logic [CW-1:0] counts [NUM_LEVELS];
  logic [9:0]    mem [NUM_LEVELS*QUEUE_DEPTH];
  logic [9:0]    rd_data;

  dtq_cmd_t  cmd;
  dtq_cand_t chain [NUM_TIMERS+1];
  dtq_cand_t seg_reg;
  logic [SW-1:0] seg;
  logic armed [NUM_TIMERS];
  logic [6:0] order [NUM_TIMERS];
  logic [PrioW-1:0] tlevel [NUM_TIMERS];
  logic drop_valid;
  logic [6:0] drop_order;

  logic [LW-1:0] dlvl;
  logic any_sent;
  logic [23:0] out_data;
  logic out_last;

  // Clamped priority and addressed timer state.
  logic [PrioW-1:0] in_lvl;
  logic [LW-1:0] lv;
  logic tid_ok;
  logic [TidW-1:0] tix;
  logic [5:0] tsel;
  assign in_lvl = (32'(s_axis_tdata[16:15]) >= NUM_LEVELS) ?
                  PrioW'(NUM_LEVELS - 1) : s_axis_tdata[16:15];
  assign tid_ok = 32'(timer_id) < NUM_TIMERS;
  assign tix    = tid_ok ? timer_id : '0;
  assign tsel   = 6'(timer_id);
  assign lv     = LW'(lvl);

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    dtq_cell #(.Index(g)) u_cell (
      .clk(clk), .rst(rst), .cmd(cmd), .now(current_time),
      .cand_in((g % SEG == 0) ? chain[0] : chain[g]), .cand_out(chain[g+1]),
      .armed(armed[g]), .order(order[g]), .level(tlevel[g]),
      .seq(arm_sequence), .drop_valid(drop_valid), .drop_order(drop_order)
    );
  end

  // The chain is cut every eight cells by seg_reg; one segment per cycle.
  always_comb begin
    chain[0] = seg_reg;
  end

  logic sel_armed;
  logic [6:0] sel_order;
  logic [PrioW-1:0] sel_level;
  logic [TimeW:0] rel_sum;
  assign sel_armed = tid_ok ? armed[tix] : 1'b0;
  assign sel_order = order[tix];
  assign sel_level = tlevel[tix];
  assign rel_sum = {1'b0, current_time} + {1'b0, treq};

  dtq_cand_t seg_end;
  always_comb begin
    int hi;
    hi = (32'(seg) + 1) * SEG;
    if (hi > NUM_TIMERS) hi = NUM_TIMERS;
    seg_end = chain[hi];
  end

  logic fire_now;
  assign fire_now = (state == S_FIRE) && (32'(seg) == NSEG) && seg_reg.found;

  function automatic logic [CW-1:0] inc(logic [CW-1:0] c);
    return c + CW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (state == S_READ) rd_data <= mem[MW'(32'(dlvl) * QUEUE_DEPTH + 32'(heads[dlvl]))];
  end

  logic [LW-1:0] push_lvl;
  logic [9:0]    push_ent;
  logic          push_req;
  logic          push_full;
  logic [QW:0]   push_sum;
  logic [QW-1:0] push_slot;
  assign push_full = 32'(counts[push_lvl]) >= QUEUE_DEPTH;
  assign push_sum  = (QW+1)'(heads[push_lvl]) + (QW+1)'(counts[push_lvl]);
  assign push_slot = (32'(push_sum) >= QUEUE_DEPTH) ?
                     QW'(32'(push_sum) - QUEUE_DEPTH) : QW'(push_sum);

  always_ff @(posedge clk) begin
    if (push_req && !push_full)
      mem[MW'(32'(push_lvl) * QUEUE_DEPTH + 32'(push_slot))] <= push_ent;
  end

  always_comb begin
    cmd = '0;
    cmd.sel = tsel;
    cmd.expiry = treq;
    cmd.level = lvl;
    drop_valid = 1'b0;
    drop_order = sel_order;
    push_req = 1'b0;
    push_lvl = lv;
    push_ent = {2'b00, task_id};
    if (state == S_IDLE && s_axis_tvalid) begin
      // nothing
    end
    if (state == S_SCAN && op == OP_POST) begin
      push_req = 1'b1;
    end else if (state == S_SCAN && (op == OP_EXP_ABS || op == OP_EXP_REL) && tid_ok) begin
      cmd.set_exp = 1'b1;
      if (op == OP_EXP_REL) cmd.expiry = rel_sum[TimeW] ? '1 : rel_sum[TimeW-1:0];
      drop_valid = sel_armed;
    end else if (state == S_SCAN && op == OP_ARM && tid_ok) begin
      cmd.arm = 1'b1;
      drop_valid = sel_armed;
    end else if (state == S_SCAN && op == OP_CANCEL && sel_armed) begin
      cmd.disarm = 1'b1;
      drop_valid = 1'b1;
      push_req = 1'b1;
      push_lvl = LW'(sel_level);
      push_ent = {2'b11, 4'b0, timer_id};
    end else if (fire_now) begin
      cmd.sel = seg_reg.idx;
      cmd.disarm = 1'b1;
      drop_valid = 1'b1;
      drop_order = seg_reg.order;
      push_req = 1'b1;
      push_lvl = LW'(seg_reg.level);
      push_ent = {2'b10, 2'b0, seg_reg.idx};
    end
  end

  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;

  function automatic logic [1:0] st_now();
    return (push_req && push_full) ? ST_FULL : ST_OK;
  endfunction

  // Last beat of a dispatch when no lower or current queue holds more.
  function automatic logic last_disp();
    logic r;
    r = 1'b1;
    for (int i = 0; i < NUM_LEVELS; i++)
      if (i <= 32'(dlvl) && counts[i] != 0) r = 1'b0;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      current_time <= '0;
      arm_sequence <= '0;
      seg_reg <= '0;
      seg <= '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        heads[i] <= '0;
        counts[i] <= '0;
      end
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) m_axis_tvalid <= 1'b0;
      if (push_req) begin
        if (push_full) st <= ST_FULL;
        else counts[push_lvl] <= inc(counts[push_lvl]);
      end
      if (drop_valid && arm_sequence != 0 && !cmd.arm) arm_sequence <= arm_sequence - 7'd1;
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            op       <= s_axis_tdata[2:0];
            task_id  <= s_axis_tdata[10:3];
            timer_id <= s_axis_tdata[14:11];
            lvl      <= in_lvl;
            treq     <= s_axis_tdata[64:17];
            st       <= ST_OK;
            fired    <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          seg_reg <= '0;
          seg <= '0;
          if (op == OP_ARM && tid_ok)
            arm_sequence <= sel_armed ? arm_sequence : arm_sequence + 7'd1;
          if (op == OP_TICK) begin
            current_time <= treq;
            state <= S_FIRE;
          end else if (op == OP_DISPATCH) begin
            dlvl <= LW'(NUM_LEVELS - 1);
            any_sent <= 1'b0;
            state <= S_DISP;
          end else begin
            out_data <= {4'b0, 5'b0, st_now(), 13'b0};
            out_last <= 1'b1;
            state <= S_OUT;
          end
        end
        S_FIRE: begin
          // seg_reg holds the best of the segments walked so far.
          if (32'(seg) == NSEG) begin
            if (seg_reg.found) begin
              fired <= fired + 5'd1;
              seg_reg <= '0;
              seg <= '0;
            end else begin
              out_data <= {4'b0, fired, st, 13'b0};
              out_last <= 1'b1;
              state <= S_OUT;
            end
          end else begin
            seg_reg <= seg_end;
            seg <= seg + SW'(1);
          end
        end
        S_DISP: begin
          if (counts[dlvl] != 0) begin
            state <= S_READ;
          end else if (dlvl == 0) begin
            if (!any_sent) begin
              out_data <= {4'b0, 5'b0, ST_EMPTY, 13'b0};
              out_last <= 1'b1;
              state <= S_OUT;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            dlvl <= dlvl - LW'(1);
          end
        end
        S_READ: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            heads[dlvl] <= (32'(heads[dlvl]) == QUEUE_DEPTH - 1) ? '0 :
                           heads[dlvl] + QW'(1);
            counts[dlvl] <= counts[dlvl] - CW'(1);
            any_sent <= 1'b1;
            state <= S_OUT;
            out_last <= 1'b0;
            out_data <= '0;
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            if (op == OP_DISPATCH && any_sent) begin
              m_axis_tdata <= {11'b0, 2'(dlvl), rd_data[8],
                               rd_data[7:0], rd_data[9] ? KIND_TIMER : KIND_TASK};
              m_axis_tlast <= last_disp();
              state <= last_disp() ? S_IDLE : S_DISP;
            end else begin
              m_axis_tdata <= out_data;
              m_axis_tlast <= out_last;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/dtq_cell.sv =====
module dtq_cell #(
  parameter int Index = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dtq_pkg::dtq_cmd_t       cmd,
  input  logic [dtq_pkg::TimeW-1:0] now,
  input  dtq_pkg::dtq_cand_t      cand_in,
  output dtq_pkg::dtq_cand_t      cand_out,
  output logic                    armed,
  output logic [6:0]              order,
  output logic [dtq_pkg::PrioW-1:0] level,
  input  logic [6:0]              seq,
  input  logic                    drop_valid,
  input  logic [6:0]              drop_order
);
  import dtq_pkg::*;

  logic [TimeW-1:0] expiry;
  logic             hit;
  logic             better;

  assign hit = (cmd.sel == 6'(Index));

  always_ff @(posedge clk) begin
    if (rst) begin
      armed  <= 1'b0;
      order  <= '0;
      level  <= '0;
      expiry <= '0;
    end else begin
      // Ranks above a removed timer close the gap.
      if (drop_valid && armed && !hit && order > drop_order) begin
        order <= order - 7'd1;
      end
      if (hit && cmd.set_exp) begin
        expiry <= cmd.expiry;
        armed  <= 1'b0;
        order  <= '0;
      end else if (hit && cmd.arm) begin
        armed <= 1'b1;
        level <= cmd.level;
        // A re-armed timer first leaves the ranks, so the count is one lower.
        order <= armed ? seq - 7'd1 : seq;
      end else if (hit && cmd.disarm) begin
        armed <= 1'b0;
        order <= '0;
      end
    end
  end

  always_comb begin
    better = armed && expiry <= now &&
             (!cand_in.found || expiry < cand_in.expiry ||
              (expiry == cand_in.expiry && order < cand_in.order));
    cand_out = cand_in;
    if (better) begin
      cand_out.found  = 1'b1;
      cand_out.idx    = 6'(Index);
      cand_out.expiry = expiry;
      cand_out.order  = order;
      cand_out.level  = level;
    end
  end
endmodule
